### hdl/gwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

  // Pattern store capacity used as the top-level default
  localparam int MAX_PATTERN_DEF = 32;

  // Pattern bytes with a wildcard meaning
  localparam logic [7:0] CH_STAR     = 8'd42;
  localparam logic [7:0] CH_QUESTION = 8'd63;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] level;
  } q_stat_t;

endpackage

`default_nettype wire

### hdl/gwm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gwm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface gwm_result_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

### hdl/gwm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_front
  import gwm_pkg::*;
(
  gwm_item_if.sink item,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     cmd
);

  assign item.ready = !q_stat.full;
  assign push       = item.valid && !q_stat.full;

  // Opcode decode into a queue command
  always_comb begin
    cmd.ch = item.char_code;
    unique case (item.opcode)
      OP_CLEAR:  cmd.op = OP_CLEAR;
      OP_APPEND: cmd.op = OP_APPEND;
      OP_TEXT:   cmd.op = OP_TEXT;
      default:   cmd.op = OP_END;
    endcase
  end

endmodule

`default_nettype wire

### hdl/gwm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_queue
  import gwm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    cmd_in,
  input  logic    pop,
  output logic    q_valid,
  output cmd_t    cmd_out,
  output q_stat_t q_stat
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] level;

  assign q_valid      = (level != '0);
  assign cmd_out      = slots[rptr];
  assign q_stat.level = level;
  assign q_stat.empty = (level == '0);
  assign q_stat.full  = (level == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/gwm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gwm_back
  import gwm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  cmd_t                             q_cmd,
  output logic                             q_pop,
  gwm_result_if.source                     result,
  output logic [$clog2(MAX_PATTERN+1)-1:0] pat_len,
  output logic [MAX_PATTERN:0]             active
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int W     = MAX_PATTERN + 1;

  logic [7:0]             store [MAX_PATTERN];
  logic                   ovf;
  logic                   out_valid;
  logic                   out_matched;
  logic                   out_ovf;

  logic [MAX_PATTERN-1:0] in_pat;
  logic [MAX_PATTERN-1:0] is_star;
  logic [MAX_PATTERN-1:0] consume;
  logic [W-1:0]           add_a;
  logic [W-1:0]           add_b;
  logic [W-1:0]           add_s;
  logic [W-1:0]           closed;
  logic [W-1:0]           advanced;
  logic                   out_free;

  assign result.valid            = out_valid;
  assign result.matched          = out_matched;
  assign result.pattern_overflow = out_ovf;

  assign out_free = !out_valid || result.ready;
  assign q_pop    = q_valid && ((q_cmd.op != OP_END) || out_free);

  // Per-position classification of the stored pattern
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      in_pat[i]  = (LEN_W'(i) < pat_len);
      is_star[i] = in_pat[i] && (store[i] == CH_STAR);
      consume[i] = in_pat[i] && (store[i] != CH_STAR)
                   && ((store[i] == CH_QUESTION) || (store[i] == q_cmd.ch));
    end
  end

  // Star closure as a carry chain: generate = active on a star, propagate = star
  assign add_a  = {1'b0, active[MAX_PATTERN-1:0] & is_star};
  assign add_b  = {1'b0, is_star};
  assign add_s  = add_a + add_b;
  assign closed = active | (add_s ^ add_a ^ add_b);

  always_comb begin
    advanced = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (closed[i] && is_star[i]) begin
        advanced[i] = 1'b1;
      end
      if (closed[i] && consume[i]) begin
        advanced[i+1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_APPEND) && (pat_len < LEN_W'(MAX_PATTERN))) begin
      store[pat_len[IDX_W-1:0]] <= q_cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == OP_END)) begin
      out_matched <= closed[pat_len];
      out_ovf     <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      ovf       <= 1'b0;
      active    <= W'(1);
      out_valid <= 1'b0;
    end else begin
      // a new result takes precedence over the transfer of the old one
      if (q_pop && (q_cmd.op == OP_END)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_cmd.op)
          OP_CLEAR: begin
            pat_len <= '0;
            ovf     <= 1'b0;
            active  <= W'(1);
          end
          OP_APPEND: begin
            if (pat_len < LEN_W'(MAX_PATTERN)) begin
              pat_len <= pat_len + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end
          OP_TEXT: begin
            active <= advanced;
          end
          OP_END: begin
            active <= W'(1);
          end
          default: begin
            active <= active;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### hdl/glob_wildcard_matcher_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Glob matcher for '*' (any run, empty included) and '?' (exactly one byte).
// Items carry an opcode and a byte: clear pattern, append pattern byte, text
// byte, end of text. Only end of text yields a result transfer, carrying the
// match bit and the sticky overflow flag (set when an append finds the store
// at MAX_PATTERN bytes; the byte is dropped). A '*' in the pattern is always a
// wildcard, whatever the text byte. End of text resets the active positions,
// the pattern stays until the next clear. Throughput is one item per cycle in
// any opcode mix while the receiver takes each result; an end-of-text item
// passes through the command queue and then the output register. The front
// decodes and writes a two-entry command queue; the back pops one command per
// cycle and updates the whole active-position vector at once, the star
// closure being one MAX_PATTERN+1 bit carry chain. The back stalls only when
// an end-of-text command meets a result still held in the output register.

module glob_wildcard_matcher_top
  import gwm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  gwm_item_if.sink     item,
  gwm_result_if.source result
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  q_stat_t q_stat;

  // queue to back
  logic    q_valid;
  cmd_t    q_cmd;
  logic    q_pop;

  // back state, watched by the checks below
  logic [LEN_W-1:0]     pat_len;
  logic [MAX_PATTERN:0] active;

  gwm_front u_front (
    .item   (item),
    .q_stat (q_stat),
    .push   (push),
    .cmd    (push_cmd)
  );

  gwm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (push_cmd),
    .pop     (q_pop),
    .q_valid (q_valid),
    .cmd_out (q_cmd),
    .q_stat  (q_stat)
  );

  gwm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .result  (result),
    .pat_len (pat_len),
    .active  (active)
  );

  // Queue never holds more than its depth
  a_queue_level : assert property (@(posedge clk) disable iff (rst)
    q_stat.level <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue over depth");

  // Pattern length stays within capacity
  a_len_cap : assert property (@(posedge clk) disable iff (rst)
    pat_len <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  // No active position beyond the end of the pattern
  a_active_range : assert property (@(posedge clk) disable iff (rst)
    (active >> pat_len) <= (MAX_PATTERN + 1)'(1))
    else $error("active position beyond pattern end");

  // A result only appears after a command was waiting in the queue
  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(q_valid))
    else $error("result without queued command");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the glob matcher: a bit-parallel copy of the
// matcher runs beside the block, one expected result per end-of-text transfer.
module tb;
  import gwm_pkg::*;

  localparam int MAXP        = MAX_PATTERN_DEF;
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off, fills the queue
  localparam int DRAIN_WAIT  = 20;   // settle time once nothing is pending

  // Shadow matcher and store of pending match results.
  class match_scoreboard;
    logic [7:0]  pat [MAXP];
    int          plen;
    logic [MAXP:0] act;
    logic        ovf;
    logic [1:0]  match_expected [$];  // {matched, pattern_overflow}
    int          errors;

    function new();
      plen   = 0;
      act    = (MAXP + 1)'(1);
      ovf    = 1'b0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endfunction

    // a live star also enables the position after it; chains run upwards
    function logic [MAXP:0] star_close(logic [MAXP:0] s);
      for (int i = 0; i < plen; i++)
        if (s[i] && pat[i] == CH_STAR) s[i+1] = 1'b1;
      return s;
    endfunction

    function logic [MAXP:0] step_text(logic [MAXP:0] s, logic [7:0] c);
      logic [MAXP:0] nxt;
      nxt = '0;
      s = star_close(s);
      for (int i = 0; i < plen; i++) begin
        if (s[i]) begin
          if (pat[i] == CH_STAR) nxt[i] = 1'b1;
          else if (pat[i] == CH_QUESTION || pat[i] == c) nxt[i+1] = 1'b1;
        end
      end
      return nxt;
    endfunction

    function void note_item(op_t op, logic [7:0] c);
      logic [MAXP:0] fin;
      case (op)
        OP_CLEAR: begin
          plen = 0;
          ovf  = 1'b0;
          act  = (MAXP + 1)'(1);
        end
        OP_APPEND: begin
          if (plen < MAXP) begin
            pat[plen] = c;
            plen++;
          end else begin
            ovf = 1'b1;
          end
        end
        OP_TEXT: act = step_text(act, c);
        default: begin
          fin = star_close(act);
          match_expected.push_back({fin[plen], ovf});
          act = (MAXP + 1)'(1);
        end
      endcase
    endfunction

    function void check_result(logic m, logic o);
      logic [1:0] want;
      if (match_expected.size() == 0) begin
        report($sformatf("result m=%0b o=%0b with nothing pending", m, o));
      end else begin
        want = match_expected.pop_front();
        if (m !== want[1])
          report($sformatf("matched %0b, expected %0b", m, want[1]));
        if (o !== want[0])
          report($sformatf("pattern_overflow %0b, expected %0b", o, want[0]));
      end
    endfunction

    function void finish();
      if (match_expected.size() != 0)
        report($sformatf("%0d results never arrived", match_expected.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  gwm_item_if   item_ch ();
  gwm_result_if result_ch ();

  glob_wildcard_matcher_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  match_scoreboard sb;

  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int sent = 0;            // accepted item transfers so far
  bit hold_req = 1'b0;     // asks the hold-off process for one long stall
  logic hold_on = 1'b0;

  always #6 clk = ~clk;

  // Result side: check on each accepted transfer, then pick ready for the
  // next edge. Everything is read as it stood just before the edge.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.matched, result_ch.pattern_overflow);
    if (hold_on) result_ch.ready <= 1'b0;
    else         result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold-off, counted here so the sender keeps pushing meanwhile and the
  // block backs up into its input.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Hard stop in case the block wedges.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // One item transfer. Valid stays high between back-to-back items, so the
  // only assignment per step is the one that is wanted.
  task automatic send_item(input op_t op, input logic [7:0] c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.opcode    <= op;
    item_ch.char_code <= c;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(op, c);
    sent++;
  endtask

  // Small alphabet so that literals hit often; wildcard bytes appear as text
  // too, and now and then any byte at all.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(5))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h63;
      3:       return CH_STAR;
      4:       return CH_QUESTION;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One text and its end. A derived text is built to fit the current pattern
  // (star gives a short run, question any byte), then possibly spoilt by one
  // edit; a free text is random. Rarely an append lands mid-text.
  task automatic send_text(input bit derive);
    logic [7:0] txt [$];
    int k;
    if (derive) begin
      for (int i = 0; i < sb.plen; i++) begin
        if (sb.pat[i] == CH_STAR) begin
          repeat ($urandom_range(3)) txt.push_back(pick_char());
        end else if (sb.pat[i] == CH_QUESTION) begin
          txt.push_back(8'($urandom_range(255)));
        end else begin
          txt.push_back(sb.pat[i]);
        end
      end
    end else begin
      repeat ($urandom_range(10)) txt.push_back(pick_char());
    end
    if ($urandom_range(3) == 0 && txt.size() > 0) begin
      k = $urandom_range(txt.size() - 1);
      case ($urandom_range(2))
        0:       txt[k] = pick_char();
        1:       txt.delete(k);
        default: txt.insert(k, pick_char());
      endcase
    end
    foreach (txt[i]) begin
      if ($urandom_range(39) == 0) send_item(OP_APPEND, pick_char());
      send_item(OP_TEXT, txt[i]);
    end
    send_item(OP_END, 8'($urandom_range(255)));
  endtask

  // A pattern (mostly short, sometimes long, now and then past capacity)
  // followed by a few texts. Clear is skipped once in a while, so appends
  // pile onto the old pattern.
  task automatic run_round();
    int r;
    int n;
    if ($urandom_range(9) != 0) send_item(OP_CLEAR, 8'($urandom_range(255)));
    r = $urandom_range(99);
    if (r < 85)      n = $urandom_range(6);
    else if (r < 95) n = $urandom_range(31, 7);
    else             n = $urandom_range(MAXP + 4, MAXP);
    repeat (n) begin
      r = $urandom_range(19);
      if (r < 6)       send_item(OP_APPEND, CH_STAR);
      else if (r < 9)  send_item(OP_APPEND, CH_QUESTION);
      else if (r < 18) send_item(OP_APPEND, 8'(8'h61 + $urandom_range(2)));
      else             send_item(OP_APPEND, 8'($urandom_range(255)));
    end
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(29) == 0)
        send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)));
      send_text($urandom_range(9) < 6);
    end
  endtask

  initial begin
    int target;
    sb = new();
    rst = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.opcode    = OP_CLEAR;
    item_ch.char_code = 8'h00;
    result_ch.ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pattern against empty and non-empty text
    send_item(OP_END, 8'h00);
    send_item(OP_TEXT, 8'h61);
    send_item(OP_END, 8'hFF);
    // lone star: empty text, then a star byte as text
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_APPEND, CH_STAR);
    send_item(OP_END, 8'h00);
    send_item(OP_TEXT, CH_STAR);
    send_item(OP_END, 8'h00);
    // extreme bytes around both wildcards
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, CH_QUESTION);
    send_item(OP_APPEND, CH_STAR);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, CH_STAR);
    send_item(OP_TEXT, 8'h11);
    send_item(OP_TEXT, CH_QUESTION);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_END, 8'h00);
    // too short, then an append in the middle of a text
    send_item(OP_TEXT, 8'h00);
    send_item(OP_END, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_APPEND, 8'h5A);
    send_item(OP_TEXT, 8'h01);
    send_item(OP_END, 8'h00);

    // Random phases: free running, slow sender, slow receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      target = sent + 200;
      if (ph == 0) begin
        // back-to-back ends against a receiver that is holding off
        hold_req = 1'b1;
        repeat (8) send_item(OP_END, 8'($urandom_range(255)));
      end
      while (sent < target) run_round();
    end
    item_ch.valid <= 1'b0;

    while (sb.match_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.finish();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
